@@ hw/rtl/ordered_dither_rgba_pixel_assert.svh @@
`ifndef ORDERED_DITHER_RGBA_PIXEL_ASSERT_SVH
`define ORDERED_DITHER_RGBA_PIXEL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ODRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ODRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/odrp_pkg.sv @@
package odrp_pkg;

    localparam int STAGES       = 7;
    localparam int MAX_ORDER    = 8;
    localparam int BAYER_LEVELS = $clog2(MAX_ORDER);
    localparam logic [1:0] ORDER_LOG2_MAX = 2'(BAYER_LEVELS);

    localparam logic [15:0] THIRD_Q      = 16'd21845;
    localparam logic [15:0] TWO_THIRDS_Q = 16'd43691;
    localparam logic [15:0] LUM_R        = 16'd13933;
    localparam logic [15:0] LUM_G        = 16'd46871;
    localparam logic [15:0] LUM_B        = 16'd4732;
    localparam logic [16:0] Q_ONE        = 17'h10000;

    typedef enum logic [2:0] {
        CFG_ENABLE          = 3'd0,
        CFG_ORDER_LOG2      = 3'd1,
        CFG_COLOR_SELECT    = 3'd2,
        CFG_INVERT_DOTS     = 3'd3,
        CFG_EXPOSURE_GAIN   = 3'd4,
        CFG_EXPOSURE_OFFSET = 3'd5,
        CFG_CONTRAST_GAIN   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_thr;

    function automatic logic [7:0] odrp_decide(logic [16:0] value, logic [15:0] thr,
                                               logic inv);
        logic ge;
        ge = (value >= {1'b0, thr});
        return ((inv ? !ge : ge)) ? 8'hFF : 8'h00;
    endfunction

endpackage

@@ hw/rtl/ordered_dither_rgba_pixel.sv @@
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+--------------------------------------
// pixel in  | in        | i_in_valid / o_in_ready    | i_in_red/green/blue/alpha, i_pos_x/y
// pixel out | out       | o_out_valid / i_out_ready  | o_out_red/green/blue/alpha
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Seven register stages; one beat in and one out per cycle while i_out_ready holds.
// Stage pacing is set by the three multiplier ranks (exposure, contrast, luminance).
// Each stage advances when empty or when the stage after it advances, so a stall
// fills bubbles first and then holds every stage; o_in_ready drops only when full.
// Synchronous active-low reset clears valid bits and loads config defaults.
module ordered_dither_rgba_pixel
    import odrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);

    logic               r_enable;
    logic [1:0]         r_order_log2;
    logic               r_color_select;
    logic               r_invert_dots;
    logic [15:0]        r_exposure_gain;
    logic [14:0]        r_exposure_offset;
    logic [14:0]        r_contrast_gain;

    logic [STAGES-1:0]  r_vld;
    logic [STAGES-1:0]  stage_adv;

    t_pix               r_s1_pix, r_s2_pix, r_s3_pix, r_s4_pix, r_s5_pix, r_s6_pix;
    t_thr               r_s1_thr, r_s2_thr, r_s3_thr, r_s4_thr, r_s5_thr, r_s6_thr;
    logic [16:0]        r_s1_c [3];
    logic [32:0]        r_s2_p [3];
    logic signed [21:0] r_s3_d [3];
    logic signed [37:0] r_s4_q [3];
    logic [16:0]        r_s5_k [3];
    logic [16:0]        r_s6_k [3];
    logic [32:0]        r_s6_lp [3];
    logic [7:0]         r_s7_red, r_s7_green, r_s7_blue, r_s7_alpha;

    logic [1:0]              n_lv;
    logic [2*BAYER_LEVELS-1:0] n_m;
    logic [15:0]             n_t;
    logic [7:0]              n_in8 [3];
    logic signed [25:0]      n_kraw [3];
    logic [16:0]             n_k [3];
    logic [33:0]             n_lum_sum;
    logic [16:0]             n_lum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable          <= 1'b0;
            r_order_log2      <= 2'd3;
            r_color_select    <= 1'b0;
            r_invert_dots     <= 1'b0;
            r_exposure_gain   <= 16'd8192;
            r_exposure_offset <= 15'd0;
            r_contrast_gain   <= 15'd8192;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:          r_enable          <= i_cfg_data[0];
                CFG_ORDER_LOG2:      r_order_log2      <= i_cfg_data[1:0];
                CFG_COLOR_SELECT:    r_color_select    <= i_cfg_data[0];
                CFG_INVERT_DOTS:     r_invert_dots     <= i_cfg_data[0];
                CFG_EXPOSURE_GAIN:   r_exposure_gain   <= i_cfg_data;
                CFG_EXPOSURE_OFFSET: r_exposure_offset <= i_cfg_data[14:0];
                CFG_CONTRAST_GAIN:   r_contrast_gain   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // advance when empty or when downstream advances
    always_comb begin
        stage_adv[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            stage_adv[s] = !r_vld[s] || stage_adv[s+1];
        end
    end

    assign o_in_ready = stage_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (stage_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 1: Bayer threshold and Q16 conversion
    always_comb begin
        n_lv = (r_order_log2 > ORDER_LOG2_MAX) ? ORDER_LOG2_MAX : r_order_log2;
        n_m  = '0;
        for (int i = 0; i < BAYER_LEVELS; i++) begin
            if (2'(i) < n_lv) begin
                n_m = {n_m[2*BAYER_LEVELS-3:0], i_pos_x[i] ^ i_pos_y[i], i_pos_y[i]};
            end
        end
        n_t = 16'({n_m, 1'b1}) << (4'd15 - 4'({n_lv, 1'b0}));
        n_in8[0] = i_in_red;
        n_in8[1] = i_in_green;
        n_in8[2] = i_in_blue;
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[0]) begin
            r_s1_pix       <= '{red: i_in_red, green: i_in_green, blue: i_in_blue,
                                alpha: i_in_alpha};
            r_s1_thr.red   <= n_t;
            r_s1_thr.green <= n_t + THIRD_Q;
            r_s1_thr.blue  <= n_t + TWO_THIRDS_Q;
            for (int ch = 0; ch < 3; ch++) begin
                r_s1_c[ch] <= 17'({n_in8[ch], n_in8[ch]}) + 17'(n_in8[ch][7]);
            end
        end
    end

    // stage 2: exposure gain
    always_ff @(posedge i_clk) begin
        if (stage_adv[1]) begin
            r_s2_pix <= r_s1_pix;
            r_s2_thr <= r_s1_thr;
            for (int ch = 0; ch < 3; ch++) begin
                r_s2_p[ch] <= r_s1_c[ch] * r_exposure_gain;
            end
        end
    end

    // stage 3: offset and re-center on mid grey
    always_ff @(posedge i_clk) begin
        if (stage_adv[2]) begin
            r_s3_pix <= r_s2_pix;
            r_s3_thr <= r_s2_thr;
            for (int ch = 0; ch < 3; ch++) begin
                r_s3_d[ch] <= $signed({2'b00, r_s2_p[ch][32:13]})
                            + $signed({{4{r_exposure_offset[14]}}, r_exposure_offset, 3'b000})
                            - 22'sd32768;
            end
        end
    end

    // stage 4: contrast gain
    always_ff @(posedge i_clk) begin
        if (stage_adv[3]) begin
            r_s4_pix <= r_s3_pix;
            r_s4_thr <= r_s3_thr;
            for (int ch = 0; ch < 3; ch++) begin
                r_s4_q[ch] <= r_s3_d[ch] * $signed({1'b0, r_contrast_gain});
            end
        end
    end

    // stage 5: floor shift, restore mid grey, clamp
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_kraw[ch] = 26'(r_s4_q[ch] >>> 13) + 26'sd32768;
            if (n_kraw[ch] < 0) begin
                n_k[ch] = '0;
            end else if (n_kraw[ch] > $signed({9'd0, Q_ONE})) begin
                n_k[ch] = Q_ONE;
            end else begin
                n_k[ch] = n_kraw[ch][16:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[4]) begin
            r_s5_pix <= r_s4_pix;
            r_s5_thr <= r_s4_thr;
            r_s5_k   <= n_k;
        end
    end

    // stage 6: luminance products
    always_ff @(posedge i_clk) begin
        if (stage_adv[5]) begin
            r_s6_pix   <= r_s5_pix;
            r_s6_thr   <= r_s5_thr;
            r_s6_k     <= r_s5_k;
            r_s6_lp[0] <= r_s5_k[0] * LUM_R;
            r_s6_lp[1] <= r_s5_k[1] * LUM_G;
            r_s6_lp[2] <= r_s5_k[2] * LUM_B;
        end
    end

    // stage 7: threshold decision
    always_comb begin
        n_lum_sum = 34'(r_s6_lp[0]) + 34'(r_s6_lp[1]) + 34'(r_s6_lp[2]);
        n_lum     = n_lum_sum[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[6]) begin
            r_s7_alpha <= r_s6_pix.alpha;
            if (!r_enable) begin
                r_s7_red   <= r_s6_pix.red;
                r_s7_green <= r_s6_pix.green;
                r_s7_blue  <= r_s6_pix.blue;
            end else if (!r_color_select) begin
                r_s7_red   <= odrp_decide(n_lum, r_s6_thr.red, r_invert_dots);
                r_s7_green <= odrp_decide(n_lum, r_s6_thr.red, r_invert_dots);
                r_s7_blue  <= odrp_decide(n_lum, r_s6_thr.red, r_invert_dots);
            end else begin
                r_s7_red   <= odrp_decide(r_s6_k[0], r_s6_thr.red, r_invert_dots);
                r_s7_green <= odrp_decide(r_s6_k[1], r_s6_thr.green, r_invert_dots);
                r_s7_blue  <= odrp_decide(r_s6_k[2], r_s6_thr.blue, r_invert_dots);
            end
        end
    end

    assign o_out_valid = r_vld[STAGES-1];
    assign o_out_red   = r_s7_red;
    assign o_out_green = r_s7_green;
    assign o_out_blue  = r_s7_blue;
    assign o_out_alpha = r_s7_alpha;

`include "ordered_dither_rgba_pixel_assert.svh"

    `ODRP_ASSERT_NOW(a_clamp_range, r_vld[4], r_s5_k[0] <= Q_ONE && r_s5_k[1] <= Q_ONE && r_s5_k[2] <= Q_ONE, "clamp out of range")
    `ODRP_ASSERT_NOW(a_binary_out, o_out_valid && r_enable, (o_out_red == 8'h00 || o_out_red == 8'hFF) && (o_out_blue == 8'h00 || o_out_blue == 8'hFF), "dithered channel not binary")
    `ODRP_ASSERT_NOW(a_gray_equal, o_out_valid && r_enable && !r_color_select, o_out_red == o_out_green && o_out_green == o_out_blue, "grayscale channels differ")
    `ODRP_ASSERT_NEXT(a_entry_taken, i_in_valid && o_in_ready, r_vld[0], "accepted beat lost at entry")

endmodule
